@@ sv/cbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

	localparam int RAM_BANKS      = 4;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
	localparam int RAM_AW         = $clog2(RAM_DEPTH);
	localparam int RAM_OFS_W      = 13;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PW       = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT   = 2'd2;

	localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
	localparam logic [2:0] REGION_LOW_BANK   = 3'd1;
	localparam logic [2:0] REGION_HIGH_BANK  = 3'd2;
	localparam logic [2:0] REGION_MODE       = 3'd3;
	localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'b1010;
	localparam logic [7:0] OPEN_BUS       = 8'hFF;

	typedef enum logic [2:0] {
		OP_ROM    = 3'd0,
		OP_RAM_RD = 3'd1,
		OP_RAM_WR = 3'd2,
		OP_OPEN   = 3'd3,
		OP_NONE   = 3'd4
	} op_t;

	typedef struct packed {
		logic        action;
		logic [15:0] address;
		logic [7:0]  write_data;
	} in_item_t;

	typedef struct packed {
		logic        rom_fetch;
		logic [20:0] rom_address;
		logic [7:0]  read_data;
	} out_item_t;

	typedef struct packed {
		op_t               op;
		logic [20:0]       rom_address;
		logic [RAM_AW-1:0] ram_addr;
		logic [7:0]        data;
	} entry_t;

	function automatic logic [1:0] ram_bank_wrap(input logic [1:0] bank);
		logic [2:0] b;
		b = {1'b0, bank};
		for (int i = 0; i < 3; i++) begin
			if (b >= 3'(RAM_BANKS)) begin
				b = b - 3'(RAM_BANKS);
			end
		end
		return b[1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/cbc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ sv/cbc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire cbc_pkg::in_item_t             in_item,
	input  wire logic                          blocked,
	input  wire logic                          q_ready,
	output logic                               push,
	output cbc_pkg::entry_t                    push_entry
);

	logic [6:0] rom_bank_mask_q;
	logic [1:0] ram_bank_mask_q;
	logic       ram_present_q;
	logic       ram_enabled_q;
	logic [4:0] low_bank_q;
	logic [1:0] high_bank_q;
	logic       mode_q;

	logic [2:0]  region;
	logic [6:0]  lower_bank;
	logic [6:0]  upper_bank;
	logic [1:0]  ram_bank;
	logic [4:0]  new_low;

	assign in_ready = q_ready && !blocked;
	assign push     = in_valid && in_ready;
	assign region   = in_item.address[15:13];
	assign new_low  = (in_item.write_data[4:0] == 5'd0) ? 5'd1 : in_item.write_data[4:0];

	always_comb begin
		lower_bank = mode_q ? ({high_bank_q, 5'd0} & rom_bank_mask_q) : 7'd0;
		upper_bank = {high_bank_q, low_bank_q} & rom_bank_mask_q;
		ram_bank   = cbc_pkg::ram_bank_wrap(mode_q ? (high_bank_q & ram_bank_mask_q) : 2'd0);

		push_entry.rom_address = 21'd0;
		push_entry.ram_addr    = cbc_pkg::RAM_AW'({ram_bank,
			in_item.address[cbc_pkg::RAM_OFS_W-1:0]});
		push_entry.data        = in_item.write_data;
		push_entry.op          = cbc_pkg::OP_NONE;

		if (in_item.action) begin
			if (region == cbc_pkg::REGION_EXT_RAM && ram_enabled_q) begin
				push_entry.op = cbc_pkg::OP_RAM_WR;
			end
		end else if (!in_item.address[15]) begin
			push_entry.op          = cbc_pkg::OP_ROM;
			push_entry.rom_address = {in_item.address[14] ? upper_bank : lower_bank,
				in_item.address[13:0]};
		end else if (region == cbc_pkg::REGION_EXT_RAM && ram_enabled_q) begin
			push_entry.op = cbc_pkg::OP_RAM_RD;
		end else begin
			push_entry.op = cbc_pkg::OP_OPEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_mask_q <= 7'd127;
			ram_bank_mask_q <= 2'd3;
			ram_present_q   <= 1'b1;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				cbc_pkg::CFG_ROM_BANK_MASK: rom_bank_mask_q <= cfg_data[6:0];
				cbc_pkg::CFG_RAM_BANK_MASK: ram_bank_mask_q <= cfg_data[1:0];
				cbc_pkg::CFG_RAM_PRESENT:   ram_present_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q <= 1'b0;
			low_bank_q    <= 5'd1;
			high_bank_q   <= 2'd0;
			mode_q        <= 1'b0;
		end else if (push && in_item.action) begin
			unique case (region)
				cbc_pkg::REGION_RAM_ENABLE: begin
					if (ram_present_q) begin
						ram_enabled_q <= (in_item.write_data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
					end
				end
				cbc_pkg::REGION_LOW_BANK:  low_bank_q  <= new_low;
				cbc_pkg::REGION_HIGH_BANK: high_bank_q <= in_item.write_data[1:0];
				cbc_pkg::REGION_MODE:      mode_q      <= in_item.write_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/cbc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire cbc_pkg::entry_t push_entry,
	output logic                 q_ready,
	input  wire logic            pop,
	output logic                 q_valid,
	output cbc_pkg::entry_t      head
);

	cbc_pkg::entry_t                 entries_q [cbc_pkg::QUEUE_DEPTH];
	logic [cbc_pkg::QUEUE_PW-1:0]    wr_ptr_q;
	logic [cbc_pkg::QUEUE_PW-1:0]    rd_ptr_q;
	logic [cbc_pkg::QUEUE_CW-1:0]    count_q;

	assign q_ready = (count_q != cbc_pkg::QUEUE_CW'(cbc_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == cbc_pkg::QUEUE_PW'(cbc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == cbc_pkg::QUEUE_PW'(cbc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cbc_pkg::QUEUE_CW'(cbc_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ sv/cbc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire cbc_pkg::entry_t head,
	output logic                 pop,
	output logic                 clearing,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output cbc_pkg::out_item_t   out_item
);

	logic                        clr_active_q;
	logic [cbc_pkg::RAM_AW-1:0]  clr_cnt_q;
	logic                        valid_s1;
	cbc_pkg::entry_t             entry_s1;
	logic                        out_valid_q;
	cbc_pkg::out_item_t          out_item_q;
	logic                        out_adv;
	logic                        ram_en;
	logic                        ram_we;
	logic [cbc_pkg::RAM_AW-1:0]  ram_addr;
	logic [7:0]                  ram_wdata;
	logic [7:0]                  ram_rdata;
	cbc_pkg::out_item_t          result;

	assign clearing  = clr_active_q;
	assign out_adv   = !out_valid_q || out_ready;
	assign pop       = q_valid && !clr_active_q && (!valid_s1 || out_adv);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		if (clr_active_q) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = clr_cnt_q;
			ram_wdata = cbc_pkg::OPEN_BUS;
		end else begin
			ram_en    = pop && (head.op == cbc_pkg::OP_RAM_RD || head.op == cbc_pkg::OP_RAM_WR);
			ram_we    = (head.op == cbc_pkg::OP_RAM_WR);
			ram_addr  = head.ram_addr;
			ram_wdata = head.data;
		end
	end

	cbc_ram #(
		.WIDTH(8),
		.DEPTH(cbc_pkg::RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_comb begin
		result = '0;
		unique case (entry_s1.op)
			cbc_pkg::OP_ROM: begin
				result.rom_fetch   = 1'b1;
				result.rom_address = entry_s1.rom_address;
			end
			cbc_pkg::OP_RAM_RD: result.read_data = ram_rdata;
			cbc_pkg::OP_OPEN:   result.read_data = cbc_pkg::OPEN_BUS;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == cbc_pkg::RAM_AW'(cbc_pkg::RAM_DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (out_adv) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && out_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_s1 <= head;
		end
		if (valid_s1 && out_adv) begin
			out_item_q <= result;
		end
	end

`ifndef ASSERT_OFF
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !valid_s1 && !pop)
		else $error("item in flight during RAM clear");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_adv |=> valid_s1 && $stable(entry_s1))
		else $error("stalled stage one lost its item");
`endif

endmodule

`default_nettype wire

@@ sv/cartridge_bank_controller_unit.sv @@
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_write_en         cfg_index, cfg_data
// in        in         in_valid / in_ready  in_item (action, address, write_data)
// out       out        out_valid / out_ready out_item (rom_fetch, rom_address, read_data)
//
// One item per cycle sustained while out_ready is high; items pass the queue, stage one
// and the output register. The single RAM port sets the rate: at most one read or one
// write per item. After reset all 32768 bytes of external RAM are filled with 0xFF, one
// byte per cycle, and no item is accepted until that pass ends; configuration writes are
// taken throughout. A stalled output holds its result; the two-entry queue then fills.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_controller_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire cbc_pkg::in_item_t             in_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output cbc_pkg::out_item_t                 out_item
);

	logic            clearing;
	logic            q_ready;
	logic            push;
	cbc_pkg::entry_t push_entry;
	logic            pop;
	logic            q_valid;
	cbc_pkg::entry_t head;

	cbc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.blocked     (clearing),
		.q_ready     (q_ready),
		.push        (push),
		.push_entry  (push_entry)
	);

	cbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.head      (head)
	);

	cbc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

`default_nettype wire
